// ----- design/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the sprite pixel rasterizer.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int COORD_W  = 11;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam logic ACT_HEADER = 1'b0;
    localparam logic ACT_PIXEL  = 1'b1;

    localparam logic RES_FETCH = 1'b0;
    localparam logic RES_WRITE = 1'b1;

    localparam logic [1:0] REG_CLIP_MIN_X = 2'd0;
    localparam logic [1:0] REG_CLIP_MAX_X = 2'd1;
    localparam logic [1:0] REG_CLIP_MIN_Y = 2'd2;
    localparam logic [1:0] REG_CLIP_MAX_Y = 2'd3;

    localparam logic [COORD_W-1:0] CLIP_MIN_X_RST = 11'd0;
    localparam logic [COORD_W-1:0] CLIP_MAX_X_RST = 11'd319;
    localparam logic [COORD_W-1:0] CLIP_MIN_Y_RST = 11'd0;
    localparam logic [COORD_W-1:0] CLIP_MAX_Y_RST = 11'd223;

    localparam logic [3:0] PEN_TRANSPARENT = 4'hf;
    localparam logic [3:0] PEN_BANK_BASE   = 4'h8;

    typedef struct packed {
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_y;
    } clip_t;

    typedef struct packed {
        logic [10:0] origin_x;
        logic [9:0]  origin_y;
        logic [1:0]  width_code;
        logic [1:0]  height_code;
        logic        mirror_x;
        logic        mirror_y;
        logic [3:0]  colour_bank;
        logic [5:0]  column_count;
        logic [5:0]  row_count;
        logic        active;
    } sprite_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               write;
        logic               last_column;
        logic               last_row;
    } place_t;

endpackage

// ----- design/sprite_pixel_rasterizer.sv -----
// ----------------------------------------------------------------------------
// sprite_pixel_rasterizer
// Turns sprite headers into graphics fetch requests and source pixels into
// clipped, mirrored frame buffer writes.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    action, sprite_x, sprite_y, attribute_word,
//                                    tile_low, pixel_value
//   output    out_valid / out_ready  result_kind, pixel_x, pixel_y, pen_index,
//                                    fetch_offset, pixel_count
//   config    psel / penable / pready  paddr, pwdata, prdata
//
// One transfer is taken every cycle while the output is not stalled; any result
// it produces appears in the next cycle. The only stage is the output register,
// which accepts a new transfer while its current result is taken in the same cycle.
// A stall on the output holds the result and drops in_ready.
// Reset clears the sprite state; the clip registers return to 0..319, 0..223.
// ----------------------------------------------------------------------------
module sprite_pixel_rasterizer
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [9:0]                 sprite_x,
    input  logic [8:0]                 sprite_y,
    input  logic [15:0]                attribute_word,
    input  logic [15:0]                tile_low,
    input  logic [3:0]                 pixel_value,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       result_kind,
    output logic [10:0]                pixel_x,
    output logic [10:0]                pixel_y,
    output logic [11:0]                pen_index,
    output logic [23:0]                fetch_offset,
    output logic [12:0]                pixel_count,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spr_pkg::CFG_AW-1:0] paddr,
    input  logic [spr_pkg::CFG_DW-1:0] pwdata,
    output logic [spr_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    spr_pkg::clip_t   clip;
    spr_pkg::sprite_t sprite_reg;
    spr_pkg::sprite_t sprite_next;
    spr_pkg::place_t  place;

    logic        in_fire;
    logic        is_header;
    logic        produce;
    logic [2:0]  width_units;
    logic [2:0]  height_units;
    logic [5:0]  area_units;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        result_kind_reg;
    logic        result_kind_next;
    logic [10:0] pixel_x_reg;
    logic [10:0] pixel_x_next;
    logic [10:0] pixel_y_reg;
    logic [10:0] pixel_y_next;
    logic [11:0] pen_index_reg;
    logic [11:0] pen_index_next;
    logic [23:0] fetch_offset_reg;
    logic [23:0] fetch_offset_next;
    logic [12:0] pixel_count_reg;
    logic [12:0] pixel_count_next;

    assign pready = 1'b1;

    spr_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .clip    (clip)
    );

    spr_pixel_place u_place
    (
        .sprite      (sprite_reg),
        .clip        (clip),
        .pixel_value (pixel_value),
        .place       (place)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign is_header = (action == spr_pkg::ACT_HEADER);
    assign produce   = is_header || (sprite_reg.active && place.write);

    assign width_units  = {1'b0, attribute_word[13:12]} + 3'd1;
    assign height_units = {1'b0, attribute_word[10:9]} + 3'd1;
    assign area_units   = {3'd0, width_units} * {3'd0, height_units};

    always_comb
    begin
        sprite_next = sprite_reg;
        if (in_fire)
        begin
            if (is_header)
            begin
                sprite_next.origin_x     = {1'b0, sprite_x} - 11'd64;
                sprite_next.origin_y     = {1'b0, sprite_y} - 10'd64;
                sprite_next.mirror_x     = attribute_word[15];
                sprite_next.mirror_y     = attribute_word[14];
                sprite_next.width_code   = attribute_word[13:12];
                sprite_next.height_code  = attribute_word[10:9];
                sprite_next.colour_bank  = attribute_word[7:4];
                sprite_next.column_count = '0;
                sprite_next.row_count    = '0;
                sprite_next.active       = 1'b1;
            end
            else if (sprite_reg.active)
            begin
                if (place.last_column)
                begin
                    sprite_next.column_count = '0;
                    if (place.last_row)
                    begin
                        sprite_next.row_count = '0;
                        sprite_next.active    = 1'b0;
                    end
                    else
                    begin
                        sprite_next.row_count = sprite_reg.row_count + 6'd1;
                    end
                end
                else
                begin
                    sprite_next.column_count = sprite_reg.column_count + 6'd1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg && !out_ready;
        result_kind_next  = result_kind_reg;
        pixel_x_next      = pixel_x_reg;
        pixel_y_next      = pixel_y_reg;
        pen_index_next    = pen_index_reg;
        fetch_offset_next = fetch_offset_reg;
        pixel_count_next  = pixel_count_reg;
        if (in_fire && produce)
        begin
            out_valid_next = 1'b1;
            if (is_header)
            begin
                result_kind_next  = spr_pkg::RES_FETCH;
                pixel_x_next      = '0;
                pixel_y_next      = '0;
                pen_index_next    = '0;
                fetch_offset_next = {attribute_word[1:0], tile_low, 6'd0};
                pixel_count_next  = {area_units[4:0], 8'd0};
            end
            else
            begin
                result_kind_next  = spr_pkg::RES_WRITE;
                pixel_x_next      = place.pos_x;
                pixel_y_next      = place.pos_y;
                pen_index_next    = {spr_pkg::PEN_BANK_BASE, sprite_reg.colour_bank,
                                     pixel_value};
                fetch_offset_next = '0;
                pixel_count_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sprite_reg    <= sprite_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_kind_reg  <= result_kind_next;
        pixel_x_reg      <= pixel_x_next;
        pixel_y_reg      <= pixel_y_next;
        pen_index_reg    <= pen_index_next;
        fetch_offset_reg <= fetch_offset_next;
        pixel_count_reg  <= pixel_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pen_index    = pen_index_reg;
    assign fetch_offset = fetch_offset_reg;
    assign pixel_count  = pixel_count_reg;

`ifndef SYNTHESIS
    a_header_starts_sprite: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_header |=> sprite_reg.active && (sprite_reg.column_count == 6'd0)
            && (sprite_reg.row_count == 6'd0))
        else $error("header transfer did not restart the sprite");

    a_idle_pixel_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !is_header && !sprite_reg.active |=> !sprite_reg.active
            && $stable(sprite_reg.column_count) && $stable(sprite_reg.row_count))
        else $error("pixel transfer without a sprite changed the counters");

    a_write_pen_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == spr_pkg::RES_WRITE) |->
            (pen_index[3:0] != spr_pkg::PEN_TRANSPARENT)
            && (pen_index[11:8] == spr_pkg::PEN_BANK_BASE) && (pixel_count == 13'd0))
        else $error("pixel write carries a transparent pen or fetch data");

    a_fetch_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == spr_pkg::RES_FETCH) |->
            (pixel_x == 11'd0) && (pixel_y == 11'd0) && (pen_index == 12'd0)
            && (pixel_count != 13'd0))
        else $error("fetch request carries pixel write data");
`endif

endmodule

// ----- design/spr_apb_regs.sv -----
// ----------------------------------------------------------------------------
// spr_apb_regs
// Clip rectangle registers behind an APB-style port.
// ----------------------------------------------------------------------------
module spr_apb_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spr_pkg::CFG_AW-1:0] paddr,
    input  logic [spr_pkg::CFG_DW-1:0] pwdata,
    output logic [spr_pkg::CFG_DW-1:0] prdata,
    output spr_pkg::clip_t             clip
);

    spr_pkg::clip_t clip_reg;
    logic [1:0]     reg_index;
    logic           wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign clip      = clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.min_x <= spr_pkg::CLIP_MIN_X_RST;
            clip_reg.max_x <= spr_pkg::CLIP_MAX_X_RST;
            clip_reg.min_y <= spr_pkg::CLIP_MIN_Y_RST;
            clip_reg.max_y <= spr_pkg::CLIP_MAX_Y_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                spr_pkg::REG_CLIP_MIN_X: clip_reg.min_x <= pwdata[spr_pkg::COORD_W-1:0];
                spr_pkg::REG_CLIP_MAX_X: clip_reg.max_x <= pwdata[spr_pkg::COORD_W-1:0];
                spr_pkg::REG_CLIP_MIN_Y: clip_reg.min_y <= pwdata[spr_pkg::COORD_W-1:0];
                spr_pkg::REG_CLIP_MAX_Y: clip_reg.max_y <= pwdata[spr_pkg::COORD_W-1:0];
                default: clip_reg <= clip_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            spr_pkg::REG_CLIP_MIN_X: prdata[spr_pkg::COORD_W-1:0] = clip_reg.min_x;
            spr_pkg::REG_CLIP_MAX_X: prdata[spr_pkg::COORD_W-1:0] = clip_reg.max_x;
            spr_pkg::REG_CLIP_MIN_Y: prdata[spr_pkg::COORD_W-1:0] = clip_reg.min_y;
            spr_pkg::REG_CLIP_MAX_Y: prdata[spr_pkg::COORD_W-1:0] = clip_reg.max_y;
            default: prdata = '0;
        endcase
    end

endmodule

// ----- design/spr_pixel_place.sv -----
// ----------------------------------------------------------------------------
// spr_pixel_place
// Destination and clip decision for one source pixel of the current sprite.
// ----------------------------------------------------------------------------
module spr_pixel_place
(
    input  spr_pkg::sprite_t sprite,
    input  spr_pkg::clip_t   clip,
    input  logic [3:0]       pixel_value,
    output spr_pkg::place_t  place
);

    logic [5:0]  last_col;
    logic [5:0]  last_row;
    logic [5:0]  col_off;
    logic [5:0]  row_off;
    logic [11:0] dx;
    logic [11:0] dy;

    assign last_col = {sprite.width_code, 4'hf};
    assign last_row = {sprite.height_code, 4'hf};
    assign col_off  = sprite.mirror_x ? (last_col - sprite.column_count) : sprite.column_count;
    assign row_off  = sprite.mirror_y ? (last_row - sprite.row_count) : sprite.row_count;

    // Sums stay within twelve-bit two's complement, so the sign bit marks
    // positions left of or above the screen origin.
    assign dx = {sprite.origin_x[10], sprite.origin_x} + {6'd0, col_off};
    assign dy = {{2{sprite.origin_y[9]}}, sprite.origin_y} + {6'd0, row_off};

    assign place.pos_x       = dx[10:0];
    assign place.pos_y       = dy[10:0];
    assign place.write       = !dx[11] && !dy[11]
                               && (dx[10:0] >= clip.min_x) && (dx[10:0] <= clip.max_x)
                               && (dy[10:0] >= clip.min_y) && (dy[10:0] <= clip.max_y)
                               && (pixel_value != spr_pkg::PEN_TRANSPARENT);
    assign place.last_column = (sprite.column_count == last_col);
    assign place.last_row    = (sprite.row_count == last_row);

endmodule

// ----- tb/sv/sprite_pixel_rasterizer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_rasterizer_test
// Self-checking testbench for the sprite pixel rasterizer. Headers and source
// pixels are driven over the valid/ready input, and every fetch request and
// pixel write on the output is compared against an internal prediction of
// the sprite position, mirroring, clipping and counters. The clip registers
// are programmed and read back over the APB port between traffic phases,
// while both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module sprite_pixel_rasterizer_test;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic        action;
        logic [9:0]  sprite_x;
        logic [8:0]  sprite_y;
        logic [15:0] attribute_word;
        logic [15:0] tile_low;
        logic [3:0]  pixel_value;
    } sprite_word_t;

    typedef struct packed {
        logic        kind;
        logic [10:0] px;
        logic [10:0] py;
        logic [11:0] pen;
        logic [23:0] offset;
        logic [12:0] count;
    } raster_op_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       action = 1'b0;
    logic [9:0]                 sprite_x = '0;
    logic [8:0]                 sprite_y = '0;
    logic [15:0]                attribute_word = '0;
    logic [15:0]                tile_low = '0;
    logic [3:0]                 pixel_value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       result_kind;
    logic [10:0]                pixel_x;
    logic [10:0]                pixel_y;
    logic [11:0]                pen_index;
    logic [23:0]                fetch_offset;
    logic [12:0]                pixel_count;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [spr_pkg::CFG_AW-1:0] paddr = '0;
    logic [spr_pkg::CFG_DW-1:0] pwdata = '0;
    logic [spr_pkg::CFG_DW-1:0] prdata;
    logic                       pready;

    // Predicted block state.
    logic [10:0] clip_lo_x = spr_pkg::CLIP_MIN_X_RST;
    logic [10:0] clip_hi_x = spr_pkg::CLIP_MAX_X_RST;
    logic [10:0] clip_lo_y = spr_pkg::CLIP_MIN_Y_RST;
    logic [10:0] clip_hi_y = spr_pkg::CLIP_MAX_Y_RST;
    logic [10:0] org_x = '0;
    logic [9:0]  org_y = '0;
    logic [1:0]  wcode = '0;
    logic [1:0]  hcode = '0;
    logic        mir_x = 1'b0;
    logic        mir_y = 1'b0;
    logic [3:0]  bank = '0;
    logic [5:0]  col = '0;
    logic [5:0]  row = '0;
    logic        sprite_live = 1'b0;

    raster_op_t expected_raster_ops[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         fed_items = 0;
    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    bit         rx_stalls = 1'b1;
    int         hold_request = 0;

    sprite_pixel_rasterizer uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .sprite_x       (sprite_x),
        .sprite_y       (sprite_y),
        .attribute_word (attribute_word),
        .tile_low       (tile_low),
        .pixel_value    (pixel_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pen_index      (pen_index),
        .fetch_offset   (fetch_offset),
        .pixel_count    (pixel_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < 40)
            $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Works out what one accepted transfer produces and advances the state.
    task automatic rasterize_item(input sprite_word_t it, output bit effective);
        raster_op_t op;
        int         w;
        int         h;
        int         dx;
        int         dy;
        bit         visible;
        op = '0;
        effective = 1'b1;
        if (it.action == spr_pkg::ACT_HEADER)
        begin
            org_x = {1'b0, it.sprite_x} - 11'd64;
            org_y = {1'b0, it.sprite_y} - 10'd64;
            mir_x = it.attribute_word[15];
            mir_y = it.attribute_word[14];
            wcode = it.attribute_word[13:12];
            hcode = it.attribute_word[10:9];
            bank = it.attribute_word[7:4];
            col = '0;
            row = '0;
            sprite_live = 1'b1;
            op.kind = spr_pkg::RES_FETCH;
            op.offset = {it.attribute_word[1:0], it.tile_low, 6'd0};
            op.count = 13'((int'(wcode) + 1) * 16 * (int'(hcode) + 1) * 16);
            expected_raster_ops.push_back(op);
        end
        else if (!sprite_live)
            effective = 1'b0;
        else
        begin
            w = (int'(wcode) + 1) * 16;
            h = (int'(hcode) + 1) * 16;
            dx = mir_x ? int'($signed(org_x)) + w - 1 - int'(col)
                       : int'($signed(org_x)) + int'(col);
            dy = mir_y ? int'($signed(org_y)) + h - 1 - int'(row)
                       : int'($signed(org_y)) + int'(row);
            visible = dx >= 0 && dy >= 0 &&
                      dx >= int'(clip_lo_x) && dx <= int'(clip_hi_x) &&
                      dy >= int'(clip_lo_y) && dy <= int'(clip_hi_y);
            if (visible && it.pixel_value != spr_pkg::PEN_TRANSPARENT)
            begin
                op.kind = spr_pkg::RES_WRITE;
                op.px = 11'(dx);
                op.py = 11'(dy);
                op.pen = {spr_pkg::PEN_BANK_BASE, bank, it.pixel_value};
                expected_raster_ops.push_back(op);
            end
            if (int'(col) + 1 >= w)
            begin
                col = '0;
                if (int'(row) + 1 >= h)
                begin
                    row = '0;
                    sprite_live = 1'b0;
                end
                else
                    row = row + 6'd1;
            end
            else
                col = col + 6'd1;
        end
    endtask

    always @(posedge clk)
    begin
        raster_op_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_raster_ops.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = expected_raster_ops.pop_front();
                compare_field("result_kind", result_kind, want.kind);
                compare_field("pixel_x", pixel_x, want.px);
                compare_field("pixel_y", pixel_y, want.py);
                compare_field("pen_index", pen_index, want.pen);
                compare_field("fetch_offset", fetch_offset, want.offset);
                compare_field("pixel_count", pixel_count, want.count);
            end
        end
    end

    initial
    begin : receiver
        int          hold_left;
        int          slot;
        logic [15:0] rx_pattern;
        hold_left = 0;
        slot = 0;
        rx_pattern = 16'hffff;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_stalls)
                out_ready <= 1'b1;
            else
            begin
                if (slot == 0)
                    rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
                out_ready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                slot = (slot + 1) % 16;
            end
        end
    end

    task automatic send_item(input sprite_word_t it);
        bit effective;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= it.action;
        sprite_x <= it.sprite_x;
        sprite_y <= it.sprite_y;
        attribute_word <= it.attribute_word;
        tile_low <= it.tile_low;
        pixel_value <= it.pixel_value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rasterize_item(it, effective);
        if (effective)
            fed_items++;
        burst_left--;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_raster_ops.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A write is always followed by a read back of the same register.
    task automatic clip_access(input logic [1:0] idx, input bit write_it,
                               input logic [10:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write_it;
        paddr <= {idx, 2'b00};
        pwdata <= spr_pkg::CFG_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        if (write_it)
        begin
            @(negedge clk);
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
        end
        @(posedge clk);
        if (prdata !== spr_pkg::CFG_DW'(value))
            report_mismatch($sformatf("clip register %0d reads %0h, expected %0h",
                                      idx, prdata, value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_clip(input logic [10:0] lo_x, input logic [10:0] hi_x,
                            input logic [10:0] lo_y, input logic [10:0] hi_y);
        clip_access(spr_pkg::REG_CLIP_MIN_X, 1'b1, lo_x);
        clip_access(spr_pkg::REG_CLIP_MAX_X, 1'b1, hi_x);
        clip_access(spr_pkg::REG_CLIP_MIN_Y, 1'b1, lo_y);
        clip_access(spr_pkg::REG_CLIP_MAX_Y, 1'b1, hi_y);
        clip_lo_x = lo_x;
        clip_hi_x = hi_x;
        clip_lo_y = lo_y;
        clip_hi_y = hi_y;
    endtask

    function automatic sprite_word_t make_word(input logic act, input logic [9:0] sx,
                                               input logic [8:0] sy,
                                               input logic [15:0] attr,
                                               input logic [15:0] tlo,
                                               input logic [3:0] pix);
        sprite_word_t w;
        w.action = act;
        w.sprite_x = sx;
        w.sprite_y = sy;
        w.attribute_word = attr;
        w.tile_low = tlo;
        w.pixel_value = pix;
        return w;
    endfunction

    function automatic sprite_word_t random_word(input logic act);
        return make_word(act, 10'($urandom), 9'($urandom), 16'($urandom),
                         16'($urandom), 4'($urandom));
    endfunction

    task automatic feed_sprite(input bit full, input int max_code);
        sprite_word_t it;
        int           n;
        it = random_word(spr_pkg::ACT_HEADER);
        it.attribute_word[13:12] = 2'($urandom_range(0, max_code));
        it.attribute_word[10:9] = 2'($urandom_range(0, max_code));
        if ($urandom_range(0, 1) == 0)
        begin
            it.sprite_x = 10'($urandom_range(30, 420));
            it.sprite_y = 9'($urandom_range(30, 320));
        end
        send_item(it);
        n = full ? (int'(it.attribute_word[13:12]) + 1) * (int'(it.attribute_word[10:9]) + 1)
                   * 256 : $urandom_range(0, 70);
        repeat (n)
        begin
            it = random_word(spr_pkg::ACT_PIXEL);
            if ($urandom_range(0, 4) == 0)
                it.pixel_value = spr_pkg::PEN_TRANSPARENT;
            send_item(it);
        end
    endtask

    task automatic test_register_access();
        clip_access(spr_pkg::REG_CLIP_MIN_X, 1'b0, spr_pkg::CLIP_MIN_X_RST);
        clip_access(spr_pkg::REG_CLIP_MAX_X, 1'b0, spr_pkg::CLIP_MAX_X_RST);
        clip_access(spr_pkg::REG_CLIP_MIN_Y, 1'b0, spr_pkg::CLIP_MIN_Y_RST);
        clip_access(spr_pkg::REG_CLIP_MAX_Y, 1'b0, spr_pkg::CLIP_MAX_Y_RST);
        set_clip(11'd2047, 11'd2047, 11'd2047, 11'd2047);
        set_clip(11'd0, 11'd0, 11'd0, 11'd0);
    endtask

    task automatic test_edge_cases();
        set_clip(11'd0, 11'd2047, 11'd0, 11'd2047);
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd3));
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd0));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd0));
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd1023, 9'd511, 16'hffff, 16'hffff,
                            4'd15));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd1023, 9'd511, 16'hffff, 16'hffff,
                            4'd15));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd0));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd14));
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd100, 9'd100, 16'h80a0, 16'h1234, 4'd0));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd1));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd2));
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd200, 9'd150, 16'h5050, 16'h8001, 4'd0));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd7));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd9));
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd64, 9'd64, 16'h2201, 16'h0000, 4'd0));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd15));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd4));
        wait_idle();
        set_clip(11'd300, 11'd100, 11'd200, 11'd50);
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd200, 9'd150, 16'h0030, 16'h0001, 4'd0));
        send_item(make_word(spr_pkg::ACT_PIXEL, 10'd0, 9'd0, 16'h0000, 16'h0000, 4'd6));
        wait_idle();
    endtask

    task automatic test_sprite_completion();
        sprite_word_t it;
        set_clip(spr_pkg::CLIP_MIN_X_RST, spr_pkg::CLIP_MAX_X_RST,
                 spr_pkg::CLIP_MIN_Y_RST, spr_pkg::CLIP_MAX_Y_RST);
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd70, 9'd80, 16'hc0f0, 16'h0042, 4'd0));
        repeat (256 + 4)
        begin
            it = random_word(spr_pkg::ACT_PIXEL);
            send_item(it);
        end
        wait_idle();
    endtask

    task automatic test_output_stall();
        sprite_word_t it;
        set_clip(11'd0, 11'd2047, 11'd0, 11'd2047);
        rx_stalls = 1'b0;
        gaps_on = 1'b0;
        hold_request = 200;
        send_item(make_word(spr_pkg::ACT_HEADER, 10'd128, 9'd128, 16'h1210, 16'h0777, 4'd0));
        repeat (60)
        begin
            it = random_word(spr_pkg::ACT_PIXEL);
            it.pixel_value = 4'($urandom_range(0, 14));
            send_item(it);
        end
        wait_idle();
        gaps_on = 1'b1;
        rx_stalls = 1'b1;
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          start;
        int          sel;
        logic [10:0] lo_x;
        logic [10:0] lo_y;
        for (phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            lo_x = 11'($urandom_range(0, 400));
            lo_y = 11'($urandom_range(0, 300));
            case (phase)
                0: set_clip(spr_pkg::CLIP_MIN_X_RST, spr_pkg::CLIP_MAX_X_RST,
                            spr_pkg::CLIP_MIN_Y_RST, spr_pkg::CLIP_MAX_Y_RST);
                1: set_clip(11'd0, 11'd2047, 11'd0, 11'd2047);
                4: set_clip(11'd300, 11'd100, 11'd250, 11'd20);
                5: set_clip(11'd0, 11'd0, 11'd0, 11'd0);
                default: set_clip(lo_x, lo_x + 11'($urandom_range(0, 300)),
                                  lo_y, lo_y + 11'($urandom_range(0, 250)));
            endcase
            rx_stalls = (phase != 1);
            gaps_on = (phase != 3);
            start = fed_items;
            while (fed_items - start < 100)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    feed_sprite(1'b0, 3);
                else if (sel == 7)
                    feed_sprite(1'b1, ($urandom_range(0, 3) == 0) ? 1 : 0);
                else
                    repeat ($urandom_range(1, 6))
                        send_item(random_word(1'($urandom)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_register_access();
        test_edge_cases();
        test_sprite_completion();
        test_output_stall();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
